// File: src/dafp_pkg.sv
// Shared widths, stage payload types and angle table functions for the dihedral angle pipeline.
package dafp_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int CORDIC_STAGES   = 16;

   localparam int POINT_FIELDS = 12;
   localparam int VEC_FIELDS   = 9;
   localparam int REQ_W        = POINT_FIELDS * COORD_WIDTH;
   localparam int OUT_W        = 9 + ANGLE_FRAC_BITS;

   // Datapath widths after block scaling
   localparam int DIFF_W    = COORD_WIDTH + 1;
   localparam int MAG_W     = COORD_WIDTH;
   localparam int NB_W      = 6;
   localparam int NORM_BITS = 12;
   localparam int SHIFT_W   = 5;
   localparam int SC_W      = NORM_BITS + 1;
   localparam int CROSS_W   = 2 * SC_W + 1;
   localparam int Q_W       = 2 * NORM_BITS + 2;
   localparam int A_W       = 40;
   localparam int X_W       = 54;

   // Square root of len_sq * 2^16
   localparam int ROOT_FRAC   = 8;
   localparam int ROOT_W      = (Q_W + 2 * ROOT_FRAC) / 2;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_STEP   = 3;
   localparam int SQRT_STAGES = (ROOT_W + SQRT_STEP - 1) / SQRT_STEP;

   // Split multiply and rotation
   localparam int A_LO_W    = 20;
   localparam int A_HI_W    = A_W - A_LO_W;
   localparam int P_LO_W    = ROOT_W + A_LO_W;
   localparam int P_HI_W    = ROOT_W + 1 + A_HI_W;
   localparam int CORD_W    = 64;
   localparam int PHASE_W   = 32;
   localparam int DEG_W     = 9;
   localparam int PROD_W    = PHASE_W + DEG_W;
   localparam logic [DEG_W-1:0]   FULL_CIRCLE = DEG_W'(360);
   localparam logic [PHASE_W-1:0] HALF_TURN   = 32'h8000_0000;
   localparam int ANGLE_LIMIT = 360 << ANGLE_FRAC_BITS;

   localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

   typedef struct packed {
      logic signed [A_W-1:0] dot_a;
      logic signed [X_W-1:0] dot_x;
      logic [Q_W-1:0]        len_sq;
   } front_out_type;

   typedef struct packed {
      logic signed [A_W-1:0] dot_a;
      logic signed [X_W-1:0] dot_x;
      logic [ROOT_W-1:0]     root;
   } sqrt_out_type;

   // Restoring long division, used for elaboration-time constants only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Rotation angle atan(2^-idx) in units of 2^-32 turn
   function automatic logic [31:0] atan_entry(input int idx);
      logic signed [63:0] acc;
      logic [63:0]        term;
      logic [63:0]        rq;
      logic [63:0]        quo;
      acc = '0;
      if (idx == 0) begin
         acc = $signed(PI_Q60 >> 2);
      end else begin
         for (int k = 0; (2 * k + 1) * idx <= 60; k++) begin
            term = udiv64(64'd1 << (60 - (2 * k + 1) * idx), 64'(2 * k + 1));
            if ((k & 1) == 1) begin
               acc = acc - $signed(term);
            end else begin
               acc = acc + $signed(term);
            end
         end
      end
      rq  = $unsigned(acc) >> 28;
      quo = udiv64(rq << 32, PI_Q60 >> 27);
      return quo[31:0];
   endfunction

endpackage

// File: src/dafp_front.sv
// Front stages: bond vectors, block scaling, cross products and dot products.
module dafp_front
   import dafp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [REQ_W-1:0]     in_data,
   output logic                 out_valid,
   output front_out_type        out_data
);

   logic [4:0] valid_ff;

   logic signed [DIFF_W-1:0] diff_ff  [VEC_FIELDS];
   logic signed [DIFF_W-1:0] diff_in  [VEC_FIELDS];
   logic signed [DIFF_W-1:0] diff2_ff [VEC_FIELDS];
   logic [SHIFT_W-1:0]       shift_ff;
   logic [SHIFT_W-1:0]       shift_in;
   logic signed [SC_W-1:0]   scaled_ff [VEC_FIELDS];
   logic signed [SC_W-1:0]   scaled_in [VEC_FIELDS];
   logic signed [SC_W-1:0]   b1_ff [3];
   logic signed [CROSS_W-1:0] n1_ff [3];
   logic signed [CROSS_W-1:0] n2_ff [3];
   logic signed [CROSS_W-1:0] n1_in [3];
   logic signed [CROSS_W-1:0] n2_in [3];
   logic [Q_W-1:0]           len_sq_ff;
   logic [Q_W-1:0]           len_sq_in;
   front_out_type            out_ff;
   front_out_type            out_in;

   // Move valid bits along with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // Form b1, b2, b3 from consecutive points
   always_comb begin
      for (int i = 0; i < VEC_FIELDS; i++) begin
         diff_in[i] = DIFF_W'($signed(in_data[(i + 3) * COORD_WIDTH +: COORD_WIDTH]))
                    - DIFF_W'($signed(in_data[i * COORD_WIDTH +: COORD_WIDTH]));
      end
   end

   // Find the block exponent from the widest magnitude
   always_comb begin
      logic [MAG_W-1:0] mag_or;
      logic [NB_W-1:0]  nb;
      mag_or = '0;
      nb     = '0;
      for (int i = 0; i < VEC_FIELDS; i++) begin
         mag_or = mag_or | (diff_ff[i][DIFF_W-1] ? ~diff_ff[i][MAG_W-1:0]
                                                 : diff_ff[i][MAG_W-1:0]);
      end
      for (int b = 0; b < MAG_W; b++) begin
         if (mag_or[b]) begin
            nb = NB_W'(b + 1);
         end
      end
      shift_in = (nb > NB_W'(NORM_BITS)) ? SHIFT_W'(nb - NB_W'(NORM_BITS)) : '0;
   end

   // Scale all components by the common shift
   always_comb begin
      for (int i = 0; i < VEC_FIELDS; i++) begin
         scaled_in[i] = SC_W'(diff2_ff[i] >>> shift_ff);
      end
   end

   // Cross products and squared length of b2
   always_comb begin
      n1_in[0] = CROSS_W'(scaled_ff[1] * scaled_ff[5]) - CROSS_W'(scaled_ff[2] * scaled_ff[4]);
      n1_in[1] = CROSS_W'(scaled_ff[2] * scaled_ff[3]) - CROSS_W'(scaled_ff[0] * scaled_ff[5]);
      n1_in[2] = CROSS_W'(scaled_ff[0] * scaled_ff[4]) - CROSS_W'(scaled_ff[1] * scaled_ff[3]);
      n2_in[0] = CROSS_W'(scaled_ff[4] * scaled_ff[8]) - CROSS_W'(scaled_ff[5] * scaled_ff[7]);
      n2_in[1] = CROSS_W'(scaled_ff[5] * scaled_ff[6]) - CROSS_W'(scaled_ff[3] * scaled_ff[8]);
      n2_in[2] = CROSS_W'(scaled_ff[3] * scaled_ff[7]) - CROSS_W'(scaled_ff[4] * scaled_ff[6]);
      len_sq_in = Q_W'(scaled_ff[3] * scaled_ff[3]) + Q_W'(scaled_ff[4] * scaled_ff[4])
                + Q_W'(scaled_ff[5] * scaled_ff[5]);
   end

   // Dot products b1.n2 and n1.n2
   always_comb begin
      out_in.dot_a  = A_W'(b1_ff[0] * n2_ff[0]) + A_W'(b1_ff[1] * n2_ff[1])
                    + A_W'(b1_ff[2] * n2_ff[2]);
      out_in.dot_x  = X_W'(n1_ff[0] * n2_ff[0]) + X_W'(n1_ff[1] * n2_ff[1])
                    + X_W'(n1_ff[2] * n2_ff[2]);
      out_in.len_sq = len_sq_ff;
   end

   // Stage registers, held while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff   <= diff_in;
         diff2_ff  <= diff_ff;
         shift_ff  <= shift_in;
         scaled_ff <= scaled_in;
         for (int i = 0; i < 3; i++) begin
            b1_ff[i] <= scaled_ff[i];
         end
         n1_ff     <= n1_in;
         n2_ff     <= n2_in;
         len_sq_ff <= len_sq_in;
         out_ff    <= out_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data  = out_ff;

endmodule

// File: src/dafp_sqrt.sv
// Pipelined digit-by-digit square root giving |b2| with eight fraction bits.
module dafp_sqrt
   import dafp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  front_out_type  in_data,
   output logic           out_valid,
   output sqrt_out_type   out_data
);

   typedef struct packed {
      logic signed [A_W-1:0] dot_a;
      logic signed [X_W-1:0] dot_x;
      logic [Q_W-1:0]        len_sq;
      logic [REM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
   } root_stage_type;

   logic [SQRT_STAGES-1:0] valid_ff;
   root_stage_type         stage_ff [SQRT_STAGES];
   root_stage_type         stage_in [SQRT_STAGES];
   root_stage_type         head;

   // Start with an empty root and remainder
   always_comb begin
      head.dot_a  = in_data.dot_a;
      head.dot_x  = in_data.dot_x;
      head.len_sq = in_data.len_sq;
      head.rem    = '0;
      head.root   = '0;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[SQRT_STAGES-2:0], in_valid};
      end
   end

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_step
      // Resolve a few root bits per stage
      always_comb begin
         root_stage_type   cur;
         logic [RAD_W-1:0] rad;
         logic [REM_W-1:0] trial;
         int               j;
         cur   = (g == 0) ? head : stage_ff[(g == 0) ? 0 : g - 1];
         rad   = {cur.len_sq, {(2 * ROOT_FRAC){1'b0}}};
         trial = '0;
         for (int t = 0; t < SQRT_STEP; t++) begin
            j = g * SQRT_STEP + t;
            if (j < ROOT_W) begin
               cur.rem = {cur.rem[REM_W-3:0], rad[RAD_W - 1 - 2 * j -: 2]};
               trial   = {cur.root, 2'b01};
               if (cur.rem >= trial) begin
                  cur.rem  = cur.rem - trial;
                  cur.root = {cur.root[ROOT_W-2:0], 1'b1};
               end else begin
                  cur.root = {cur.root[ROOT_W-2:0], 1'b0};
               end
            end
         end
         stage_in[g] = cur;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[g] <= stage_in[g];
         end
      end
   end

   assign out_valid      = valid_ff[SQRT_STAGES-1];
   assign out_data.dot_a = stage_ff[SQRT_STAGES-1].dot_a;
   assign out_data.dot_x = stage_ff[SQRT_STAGES-1].dot_x;
   assign out_data.root  = stage_ff[SQRT_STAGES-1].root;

endmodule

// File: src/dafp_cordic.sv
// Split multiply, CORDIC vectoring stages and conversion of the phase to degrees.
module dafp_cordic
   import dafp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  sqrt_out_type      in_data,
   output logic              out_valid,
   output logic [OUT_W-1:0]  out_angle
);

   typedef struct packed {
      logic [P_LO_W-1:0]        p_lo;
      logic signed [P_HI_W-1:0] p_hi;
      logic signed [X_W-1:0]    dot_x;
   } mul_type;

   typedef struct packed {
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic [PHASE_W-1:0]       z;
      logic                     zero;
   } vec_type;

   logic [1:0]             mul_valid_ff;
   logic [CORDIC_STAGES:0] rot_valid_ff;
   logic                   out_valid_ff;
   mul_type                mul_ff;
   mul_type                mul_in;
   vec_type                comb_ff;
   vec_type                comb_in;
   vec_type                rot_ff [CORDIC_STAGES+1];
   vec_type                rot_in [CORDIC_STAGES+1];
   logic [OUT_W-1:0]       angle_ff;
   logic [OUT_W-1:0]       angle_in;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= '0;
         rot_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= {mul_valid_ff[0], in_valid};
         rot_valid_ff <= {rot_valid_ff[CORDIC_STAGES-1:0], mul_valid_ff[1]};
         out_valid_ff <= rot_valid_ff[CORDIC_STAGES];
      end
   end

   // Partial products of root times b1.n2
   always_comb begin
      mul_in.p_lo  = P_LO_W'(in_data.root) * P_LO_W'(in_data.dot_a[A_LO_W-1:0]);
      mul_in.p_hi  = P_HI_W'($signed({1'b0, in_data.root}))
                   * P_HI_W'($signed(in_data.dot_a[A_W-1:A_LO_W]));
      mul_in.dot_x = in_data.dot_x;
   end

   // Combine partial products, scale the cosine term
   always_comb begin
      comb_in.y    = (CORD_W'(mul_ff.p_hi) <<< A_LO_W) + CORD_W'(mul_ff.p_lo);
      comb_in.x    = CORD_W'(mul_ff.dot_x) <<< ROOT_FRAC;
      comb_in.z    = '0;
      comb_in.zero = 1'b0;
   end

   // Fold the left half plane and flag the undefined angle
   always_comb begin
      rot_in[0]      = comb_ff;
      rot_in[0].zero = (comb_ff.x == '0) && (comb_ff.y == '0);
      if (comb_ff.x[CORD_W-1]) begin
         rot_in[0].x = -comb_ff.x;
         rot_in[0].y = -comb_ff.y;
         rot_in[0].z = HALF_TURN;
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
      localparam logic [PHASE_W-1:0] STEP_ANGLE = atan_entry(g);

      // Rotate toward the x axis
      always_comb begin
         logic signed [CORD_W-1:0] xs;
         logic signed [CORD_W-1:0] ys;
         xs = rot_ff[g].x >>> g;
         ys = rot_ff[g].y >>> g;
         rot_in[g+1] = rot_ff[g];
         if (!rot_ff[g].y[CORD_W-1]) begin
            rot_in[g+1].x = rot_ff[g].x + ys;
            rot_in[g+1].y = rot_ff[g].y - xs;
            rot_in[g+1].z = rot_ff[g].z + STEP_ANGLE;
         end else begin
            rot_in[g+1].x = rot_ff[g].x - ys;
            rot_in[g+1].y = rot_ff[g].y + xs;
            rot_in[g+1].z = rot_ff[g].z - STEP_ANGLE;
         end
      end
   end

   // Convert the phase to degrees
   always_comb begin
      logic [PROD_W-1:0] prod;
      prod     = PROD_W'(rot_ff[CORDIC_STAGES].z) * PROD_W'(FULL_CIRCLE);
      angle_in = rot_ff[CORDIC_STAGES].zero ? '0
               : OUT_W'(prod >> (PHASE_W - ANGLE_FRAC_BITS));
   end

   // Stage registers, held while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ff   <= mul_in;
         comb_ff  <= comb_in;
         rot_ff   <= rot_in;
         angle_ff <= angle_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = angle_ff;

endmodule

// File: src/dihedral_angle_four_points_top.sv
// Top level of the dihedral angle pipeline with output register and skid stage.
//
// Takes one quadruple of Q8.8 points per cycle while req_tready is high and
// returns the torsion angle about bond b-c in degrees times 128, 0 up to
// below 360. From input transfer to rsp_tvalid a result passes five front
// stages (differences, scaling, cross and dot products), seven square root
// stages, three multiply and fold stages, sixteen CORDIC stages, one degree
// conversion stage and the output register. A skid register catches a result
// that arrives while the output register waits, so input keeps flowing;
// req_tready drops only when both output register and skid register hold results.
module dihedral_angle_four_points_top
   import dafp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // point_a_x, point_a_y, point_a_z, point_b_x .. point_d_z, 16 bits each
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // dihedral_angle
   output logic [OUT_W-1:0]  rsp_tdata
);

   logic             advance;
   logic             front_valid;
   front_out_type    front_data;
   logic             sqrt_valid;
   sqrt_out_type     sqrt_data;
   logic             pipe_valid;
   logic [OUT_W-1:0] pipe_angle;

   logic             out_valid_ff;
   logic             out_valid_in;
   logic             full_ff;
   logic             full_in;
   logic [OUT_W-1:0] out_data_ff;
   logic [OUT_W-1:0] out_data_in;
   logic [OUT_W-1:0] skid_ff;
   logic [OUT_W-1:0] skid_in;

   assign advance    = !full_ff;
   assign req_tready = advance;

   dafp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   dafp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (sqrt_valid),
      .out_data  (sqrt_data)
   );

   dafp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sqrt_valid),
      .in_data   (sqrt_data),
      .out_valid (pipe_valid),
      .out_angle (pipe_angle)
   );

   // Route finished results to the output register or the skid register
   always_comb begin
      out_valid_in = out_valid_ff;
      full_in      = full_ff;
      out_data_in  = out_data_ff;
      skid_in      = skid_ff;
      if (full_ff) begin
         if (rsp_tready) begin
            out_data_in = skid_ff;
            full_in     = 1'b0;
         end
      end else if (pipe_valid) begin
         if (!out_valid_ff || rsp_tready) begin
            out_data_in  = pipe_angle;
            out_valid_in = 1'b1;
         end else begin
            skid_in = pipe_angle;
            full_in = 1'b1;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         full_ff      <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_ff     <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: src/dafp_checker.sv
// Port-level checks of the dihedral angle block, bound to the top level.
module dafp_checker
   import dafp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [OUT_W-1:0]  rsp_tdata
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Angles stay below a full circle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata < OUT_W'(ANGLE_LIMIT))
      else $error("angle out of range");

   // Backpressure on the input only while a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // No result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind dihedral_angle_four_points_top dafp_checker u_dafp_checker (.*);
